/* design/deq_pkg.sv */
// Shared types and constants of the deadline event queue.
// Used by deq_ctrl, deq_datapath and deadline_event_queue; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

  localparam int TIME_W  = 32;
  localparam int DELAY_W = 24;
  localparam int TAG_W   = 16;
  localparam int EID_W   = 16;
  localparam int KIND_W  = 3;
  localparam int RES_MAX = 16;
  localparam int FIRE_W  = 5;

  typedef enum logic [1:0] {
    MODE_SCHED  = 2'd0,
    MODE_TICK   = 2'd1,
    MODE_CANCEL = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED  = 3'd0,
    KIND_FIRED  = 3'd1,
    KIND_NEXT   = 3'd2,
    KIND_CANCEL = 3'd3,
    KIND_FULL   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    RD_IDX    = 2'd0,
    RD_HEAD   = 2'd1,
    RD_SECOND = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    idx_inc;
    logic    ins_step;
    logic    ins_fin;
    logic    can_step;
    logic    carry_ld;
    logic    pop;
    logic    emit;
    kind_t   ekind;
    logic    elast;
  } dq_cmd_t;

  typedef struct packed {
    mode_t new_mode;
    logic  new_delay_zero;
    mode_t mode_q;
    logic  full;
    logic  empty;
    logic  idx_end;
    logic  expired;
    logic  two_plus;
    logic  fire_room;
    logic  out_free;
  } dq_stat_t;

  // deadline a lies strictly after b, wrap-aware
  function automatic logic later_than(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
    logic [TIME_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[TIME_W-1];
  endfunction

endpackage

`default_nettype wire

/* design/deadline_event_queue.sv */
// Deadline event queue: timed events held in a table sorted by deadline.
// Channels: input beat (mode, now_ms, delay_ms, user_tag, cancel_id) and
// result beats (kind, event_id, tag_out, time_left, found, last), both
// valid/ready; last marks the final result of one input beat.
// One input beat is worked at a time; the next is taken once the last
// result of the previous one is in the output register, even if the
// receiver has not yet taken it. A stalled receiver holds the block in
// its emit step until the output register frees.
// Steps per beat, with N stored entries and one read of the entry
// memory per scan step (read state, then check state) during a scan:
//   schedule, delay > 0: forward scan of all N entries and shift;
//   schedule, delay 0 or full table: result beats only, no scan;
//   cancel: scan of all N entries and shift down;
//   tick: a head read and check per fired event, at most 16 per beat;
//   query: one head read and one result beat.
// Synchronous reset empties the table and sets the next id to 1; entry
// contents are not cleared, so there is no sweep after reset.
`timescale 1ns / 1ps
`default_nettype none

module deadline_event_queue #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         mode,
  input  logic [31:0]        now_ms,
  input  logic [23:0]        delay_ms,
  input  logic [15:0]        user_tag,
  input  logic [15:0]        cancel_id,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         kind,
  output logic [15:0]        event_id,
  output logic [15:0]        tag_out,
  output logic signed [31:0] time_left,
  output logic               found,
  output logic               last
);
  import deq_pkg::*;

  dq_cmd_t  cmd;
  dq_stat_t stat;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  deq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_WIDTH    (ID_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .mode      (mode),
    .now_ms    (now_ms),
    .delay_ms  (delay_ms),
    .user_tag  (user_tag),
    .cancel_id (cancel_id),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .kind      (kind),
    .event_id  (event_id),
    .tag_out   (tag_out),
    .time_left (time_left),
    .found     (found),
    .last      (last)
  );

endmodule

`default_nettype wire

/* design/deq_datapath.sv */
// Datapath of the deadline event queue: circular entry memory, counters,
// scan carry register and the output beat register. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int ID_WIDTH    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  deq_pkg::dq_cmd_t      cmd,
  output deq_pkg::dq_stat_t     stat,
  input  logic [1:0]            mode,
  input  logic [31:0]           now_ms,
  input  logic [23:0]           delay_ms,
  input  logic [15:0]           user_tag,
  input  logic [15:0]           cancel_id,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [2:0]            kind,
  output logic [15:0]           event_id,
  output logic [15:0]           tag_out,
  output logic signed [31:0]    time_left,
  output logic                  found,
  output logic                  last
);
  import deq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [TIME_W-1:0]   mem_dl  [QUEUE_DEPTH];
  logic [ID_WIDTH-1:0] mem_id  [QUEUE_DEPTH];
  logic [TAG_W-1:0]    mem_tag [QUEUE_DEPTH];

  logic [TIME_W-1:0]   rd_dl;
  logic [ID_WIDTH-1:0] rd_id;
  logic [TAG_W-1:0]    rd_tag;
  logic [AW-1:0]       rd_addr;
  logic [AW-1:0]       prev_addr;

  logic [AW-1:0]       head;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [ID_WIDTH-1:0] next_id;
  logic [ID_WIDTH-1:0] cur_id;
  mode_t               mode_q;
  logic [TIME_W-1:0]   now_q;
  logic [TAG_W-1:0]    cid_q;
  logic [TIME_W-1:0]   carry_dl;
  logic [ID_WIDTH-1:0] carry_id;
  logic [TAG_W-1:0]    carry_tag;
  logic                flag;
  logic [FIRE_W-1:0]   fires;

  logic [AW-1:0]       rd_lidx;
  logic [AW:0]         rd_sum;
  logic [AW:0]         rd_wrap;
  logic [AW-1:0]       rd_phys;
  logic [AW:0]         fin_sum;
  logic [AW:0]         fin_wrap;
  logic [AW-1:0]       fin_phys;
  logic [AW-1:0]       head_inc;
  logic [ID_WIDTH-1:0] nid_inc;
  logic [ID_WIDTH-1:0] nid_next;
  logic                later_ins;
  logic                id_match;
  logic                empty;

  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [TIME_W-1:0]   wr_dl;
  logic [ID_WIDTH-1:0] wr_id;
  logic [TAG_W-1:0]    wr_tag;

  logic [15:0]         event_id_next;
  logic [15:0]         tag_out_next;
  logic signed [31:0]  time_left_next;
  logic                found_next;

  always_comb begin
    unique case (cmd.rd_sel)
      RD_HEAD:   rd_lidx = '0;
      RD_SECOND: rd_lidx = AW'(1);
      default:   rd_lidx = idx[AW-1:0];
    endcase
  end

  assign rd_sum   = {1'b0, head} + {1'b0, rd_lidx};
  assign rd_wrap  = rd_sum - (AW + 1)'(QUEUE_DEPTH);
  assign rd_phys  = (rd_sum >= (AW + 1)'(QUEUE_DEPTH)) ? rd_wrap[AW-1:0] : rd_sum[AW-1:0];
  assign fin_sum  = {1'b0, head} + {1'b0, count[AW-1:0]};
  assign fin_wrap = fin_sum - (AW + 1)'(QUEUE_DEPTH);
  assign fin_phys = (fin_sum >= (AW + 1)'(QUEUE_DEPTH)) ? fin_wrap[AW-1:0] : fin_sum[AW-1:0];
  assign head_inc = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + 1'b1;
  assign nid_inc  = next_id + 1'b1;
  assign nid_next = (nid_inc == '0) ? ID_WIDTH'(1) : nid_inc;

  assign later_ins = later_than(rd_dl, carry_dl);
  assign id_match  = (32'(rd_id) == 32'(cid_q));
  assign empty     = (count == '0);

  assign stat.new_mode       = mode_t'(mode);
  assign stat.new_delay_zero = (delay_ms == '0);
  assign stat.mode_q         = mode_q;
  assign stat.full           = (count == CW'(QUEUE_DEPTH));
  assign stat.empty          = empty;
  assign stat.idx_end        = (idx == count);
  assign stat.expired        = !later_than(rd_dl, now_q);
  assign stat.two_plus       = (count >= CW'(2));
  assign stat.fire_room      = (fires < FIRE_W'(RES_MAX - 1));
  assign stat.out_free       = !out_valid || out_ready;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr;
    wr_dl   = carry_dl;
    wr_id   = carry_id;
    wr_tag  = carry_tag;
    if (cmd.ins_step && (flag || later_ins)) begin
      wr_en = 1'b1;
    end else if (cmd.ins_fin) begin
      wr_en   = 1'b1;
      wr_addr = fin_phys;
    end else if (cmd.can_step && flag) begin
      wr_en   = 1'b1;
      wr_addr = prev_addr;
      wr_dl   = rd_dl;
      wr_id   = rd_id;
      wr_tag  = rd_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_dl[wr_addr]  <= wr_dl;
      mem_id[wr_addr]  <= wr_id;
      mem_tag[wr_addr] <= wr_tag;
    end
    if (cmd.rd_en) begin
      rd_dl   <= mem_dl[rd_phys];
      rd_id   <= mem_id[rd_phys];
      rd_tag  <= mem_tag[rd_phys];
      rd_addr <= rd_phys;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q    <= mode_t'(mode);
      now_q     <= now_ms;
      cid_q     <= cancel_id;
      carry_dl  <= now_ms + TIME_W'(delay_ms);
      carry_id  <= next_id;
      carry_tag <= user_tag;
      cur_id    <= next_id;
    end else if (cmd.ins_step && (flag || later_ins)) begin
      carry_dl  <= rd_dl;
      carry_id  <= rd_id;
      carry_tag <= rd_tag;
    end else if (cmd.carry_ld) begin
      carry_dl  <= rd_dl;
      carry_id  <= rd_id;
      carry_tag <= rd_tag;
    end
    if (cmd.can_step) begin
      prev_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      idx       <= '0;
      next_id   <= ID_WIDTH'(1);
      flag      <= 1'b0;
      fires     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx   <= '0;
        flag  <= 1'b0;
        fires <= '0;
        if (mode_t'(mode) == MODE_SCHED) begin
          next_id <= nid_next;
        end
      end
      if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.ins_step && later_ins) begin
        flag <= 1'b1;
      end
      if (cmd.can_step && id_match) begin
        flag <= 1'b1;
      end
      if (cmd.ins_fin) begin
        count <= count + 1'b1;
      end
      if (cmd.pop) begin
        head  <= head_inc;
        count <= count - 1'b1;
        fires <= fires + 1'b1;
      end
      if (cmd.emit && (cmd.ekind == KIND_CANCEL) && flag) begin
        count <= count - 1'b1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    event_id_next  = '0;
    tag_out_next   = '0;
    time_left_next = '0;
    found_next     = 1'b0;
    unique case (cmd.ekind)
      KIND_SCHED, KIND_FULL: begin
        event_id_next = EID_W'(cur_id);
      end
      KIND_FIRED: begin
        event_id_next = EID_W'(carry_id);
        tag_out_next  = carry_tag;
      end
      KIND_NEXT: begin
        time_left_next = empty ? '1 : $signed(rd_dl - now_q);
      end
      KIND_CANCEL: begin
        event_id_next = cid_q;
        found_next    = flag;
      end
      default: begin
        event_id_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      kind      <= cmd.ekind;
      last      <= cmd.elast;
      event_id  <= event_id_next;
      tag_out   <= tag_out_next;
      time_left <= time_left_next;
      found     <= found_next;
    end
  end

endmodule

`default_nettype wire

/* design/deq_ctrl.sv */
// Controller of the deadline event queue: one-hot state machine that
// sequences scans, head pops and result beats. Depends on deq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  deq_pkg::dq_stat_t stat,
  output deq_pkg::dq_cmd_t  cmd
);
  import deq_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b000000000001,
    S_RD      = 12'b000000000010,
    S_CHK     = 12'b000000000100,
    S_TRD     = 12'b000000001000,
    S_TCHK0   = 12'b000000010000,
    S_TCHK1   = 12'b000000100000,
    S_E_IMM   = 12'b000001000000,
    S_E_SCHED = 12'b000010000000,
    S_E_FULL  = 12'b000100000000,
    S_E_CAN   = 12'b001000000000,
    S_E_QRY   = 12'b010000000000,
    S_E_TICK  = 12'b100000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   tlast;
  logic   tlast_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_IDX;
    cmd.ekind  = KIND_SCHED;
    state_next = state;
    tlast_next = tlast;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          unique case (stat.new_mode)
            MODE_SCHED: begin
              priority if (stat.new_delay_zero) state_next = S_E_IMM;
              else if (stat.full)               state_next = S_E_FULL;
              else                              state_next = S_RD;
            end
            MODE_TICK:   state_next = S_TRD;
            MODE_CANCEL: state_next = S_RD;
            MODE_QUERY: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = RD_HEAD;
              state_next = S_E_QRY;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        if (stat.idx_end) begin
          if (stat.mode_q == MODE_SCHED) begin
            cmd.ins_fin = 1'b1;
            state_next  = S_E_SCHED;
          end else begin
            state_next = S_E_CAN;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.mode_q == MODE_SCHED) cmd.ins_step = 1'b1;
        else                           cmd.can_step = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = S_RD;
      end
      S_TRD: begin
        if (stat.empty) begin
          state_next = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = RD_HEAD;
          state_next = S_TCHK0;
        end
      end
      S_TCHK0: begin
        if (!stat.expired) begin
          state_next = S_IDLE;
        end else begin
          cmd.carry_ld = 1'b1;
          if (stat.two_plus && stat.fire_room) begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SECOND;
            state_next = S_TCHK1;
          end else begin
            tlast_next = 1'b1;
            state_next = S_E_TICK;
          end
        end
      end
      S_TCHK1: begin
        tlast_next = !stat.expired;
        state_next = S_E_TICK;
      end
      S_E_TICK: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.ekind  = KIND_FIRED;
          cmd.elast  = tlast;
          cmd.pop    = 1'b1;
          state_next = tlast ? S_IDLE : S_TRD;
        end
      end
      S_E_IMM: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.ekind  = KIND_FIRED;
          state_next = S_E_SCHED;
        end
      end
      S_E_SCHED: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.ekind  = KIND_SCHED;
          cmd.elast  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_E_FULL: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.ekind  = KIND_FULL;
          cmd.elast  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_E_CAN: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.ekind  = KIND_CANCEL;
          cmd.elast  = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_E_QRY: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          cmd.ekind  = KIND_NEXT;
          cmd.elast  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      tlast <= 1'b0;
    end else begin
      state <= state_next;
      tlast <= tlast_next;
    end
  end

endmodule

`default_nettype wire
